// File: hw/rtl/satsm_pkg.sv
// ----------------------------------------------------------------------------
// satsm_pkg
// Shared types and fixed widths of the set-associative tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package satsm_pkg;

  localparam int unsigned ADDR_W = 32;  // byte address width
  localparam int unsigned MODE_W = 2;   // policy mode width
  localparam int unsigned CNT_W  = 32;  // stamp, use count and access counter width

  // Replacement policy of one access; the unused code behaves as LFU
  typedef enum logic [MODE_W-1:0] {
    MODE_FIFO = 2'd0,
    MODE_LRU  = 2'd1,
    MODE_LFU  = 2'd2
  } mode_e;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage : satsm_pkg

`default_nettype wire

// File: hw/rtl/set_assoc_tag_store_multi_policy_top.sv
// ----------------------------------------------------------------------------
// set_assoc_tag_store_multi_policy_top
// Tag store of a set-associative cache with FIFO, LRU or LFU replacement
// chosen per access.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one access item: a byte
//   address and a policy mode. Output channel (out_valid_o / out_ready_i)
//   returns one result item per access: hit flag and the way that hit or
//   was filled on a miss.
//   All state of a set (valid bits, tags, LRU stamps, use counts, FIFO fill
//   pointer) lives in one row of a single-port synchronous memory indexed by
//   set. An access reads its row into a register when accepted; in the
//   lookup state it resolves hit or victim and, once the output register
//   is free, writes the row back and loads the output register. One item
//   is in flight at a time, a limit set by the read-modify-write of the
//   set row: no new item is taken until the last lookup has finished.
//   The output register parts the two sides: a new item is accepted while a
//   finished result still waits. If the receiver stalls, the lookup holds
//   its read row and waits until the output register frees up.
//   After reset the block sweeps the memory, clearing one set row per
//   cycle until all NUM_SETS_P rows are clear, with in_ready_o held low.
//   LINE_BYTES and NUM_SETS_P must be powers of two.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_tag_store_multi_policy_top #(
  parameter int unsigned NUM_WAYS   = 2,
  parameter int unsigned NUM_SETS_P = 4,
  parameter int unsigned LINE_BYTES = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [satsm_pkg::ADDR_W-1:0]  address_i,
  input  wire logic [satsm_pkg::MODE_W-1:0]  mode_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               hit_o,
  output logic                               way_used_o
);

  import satsm_pkg::*;

  localparam int unsigned OFF_B  = $clog2(LINE_BYTES);
  localparam int unsigned SET_B  = $clog2(NUM_SETS_P);
  localparam int unsigned SET_W  = (NUM_SETS_P > 1) ? SET_B : 1;
  localparam int unsigned WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned TAG_W  = ADDR_W - OFF_B - SET_B;
  localparam int unsigned LVLS   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 0;
  localparam int unsigned LEAVES = 1 << LVLS;
  localparam int unsigned KEY_W  = CNT_W + 1;

  // One memory row holds the whole state of a set
  typedef struct packed {
    logic [NUM_WAYS-1:0]             valid;
    logic [NUM_WAYS-1:0][TAG_W-1:0]  tag;
    logic [NUM_WAYS-1:0][CNT_W-1:0]  stamp;
    logic [NUM_WAYS-1:0][CNT_W-1:0]  count;
    logic [WAY_W-1:0]                ptr;
  } set_row_t;

  state_e               state_q, state_d;
  logic [SET_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic [CNT_W-1:0]     ctr_q, ctr_d;
  logic                 out_valid_q, out_valid_d;

  // Accepted item, held while its row is read
  logic [SET_W-1:0]     set_q;
  logic [TAG_W-1:0]     tag_q;
  logic [MODE_W-1:0]    mode_q;
  logic                 hit_q;
  logic [WAY_W-1:0]     way_q;

  set_row_t             set_mem [NUM_SETS_P];
  set_row_t             rd_row_q;
  set_row_t             wr_row;
  set_row_t             new_row;

  logic [ADDR_W-1:0]    blk_addr;
  logic [SET_W-1:0]     set_in;
  logic [TAG_W-1:0]     tag_in;
  logic                 in_fire;
  logic                 out_free;
  logic                 lookup_fire;
  logic                 clr_last;
  logic                 mem_we;
  logic [SET_W-1:0]     mem_wa;

  logic [NUM_WAYS-1:0]  match;
  logic                 hit;
  logic [WAY_W-1:0]     hit_way;
  logic [WAY_W-1:0]     victim;
  logic [WAY_W-1:0]     ptr_next;
  logic [CNT_W-1:0]     ctr_inc;
  logic                 is_lru;
  logic                 is_fifo;

  logic [KEY_W-1:0]     key_tr [LVLS+1][LEAVES];
  logic [WAY_W-1:0]     idx_tr [LVLS+1][LEAVES];

  // --------------------------------------------------------------------------
  // Address split: block = address / LINE_BYTES, set and tag from the block
  // --------------------------------------------------------------------------
  assign blk_addr = address_i >> OFF_B;
  assign set_in   = SET_W'(blk_addr % NUM_SETS_P);
  assign tag_in   = TAG_W'(blk_addr >> SET_B);

  // --------------------------------------------------------------------------
  // Control sequencer
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_ready_i;
  assign clr_last = (clr_cnt_q == SET_W'(NUM_SETS_P - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    lookup_fire = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = set_q;
    clr_cnt_d   = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wa    = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + SET_W'(1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_LOOKUP: begin
        lookup_fire = out_free;
        mem_we      = out_free;
      end
      default: ;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Hit search over the ways of the row
  // --------------------------------------------------------------------------
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = rd_row_q.valid[w] && (rd_row_q.tag[w] == tag_q);
    end
    // descend so the lowest matching way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
    end
  end
  assign hit = |match;

  assign is_lru  = (mode_q == MODE_LRU);
  assign is_fifo = (mode_q == MODE_FIFO);

  // --------------------------------------------------------------------------
  // Victim tree: key is {valid, stamp or count}, so invalid ways sort first.
  // Right child wins only when strictly smaller: ties go to the lower way.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int l = 0; l <= LVLS; l++) begin
      for (int i = 0; i < LEAVES; i++) begin
        key_tr[l][i] = '1;
        idx_tr[l][i] = '0;
      end
    end
    for (int i = 0; i < NUM_WAYS; i++) begin
      key_tr[0][i] = {rd_row_q.valid[i], is_lru ? rd_row_q.stamp[i] : rd_row_q.count[i]};
      idx_tr[0][i] = WAY_W'(i);
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
        if (key_tr[l][2*i+1] < key_tr[l][2*i]) begin
          key_tr[l+1][i] = key_tr[l][2*i+1];
          idx_tr[l+1][i] = idx_tr[l][2*i+1];
        end else begin
          key_tr[l+1][i] = key_tr[l][2*i];
          idx_tr[l+1][i] = idx_tr[l][2*i];
        end
      end
    end
  end

  assign ptr_next = (rd_row_q.ptr == WAY_W'(NUM_WAYS - 1)) ? '0
                                                          : rd_row_q.ptr + WAY_W'(1);
  assign victim   = is_fifo ? rd_row_q.ptr : idx_tr[LVLS][0];
  assign ctr_inc  = ctr_q + CNT_W'(1);

  // --------------------------------------------------------------------------
  // Row update: touch the hit line, or refill the victim
  // --------------------------------------------------------------------------
  always_comb begin
    new_row = rd_row_q;
    if (hit) begin
      if (is_lru) new_row.stamp[hit_way] = ctr_inc;
      if (rd_row_q.count[hit_way] != '1) begin
        new_row.count[hit_way] = rd_row_q.count[hit_way] + CNT_W'(1);
      end
    end else begin
      new_row.valid[victim] = 1'b1;
      new_row.tag[victim]   = tag_q;
      new_row.stamp[victim] = is_lru ? ctr_inc : '0;
      new_row.count[victim] = CNT_W'(1);
      if (is_fifo) new_row.ptr = ptr_next;
    end
  end

  // Clear sweep writes an all-zero row: no valid ways, fill pointer at way 0
  assign wr_row = (state_q == ST_CLEAR) ? '0 : new_row;

  // --------------------------------------------------------------------------
  // Set memory: one write and one registered read per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) set_mem[mem_wa] <= wr_row;
    if (in_fire) rd_row_q <= set_mem[set_in];
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (lookup_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign ctr_d = lookup_fire ? ctr_inc : ctr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: hold the accepted item and the result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      set_q  <= set_in;
      tag_q  <= tag_in;
      mode_q <= mode_i;
    end
    if (lookup_fire) begin
      hit_q <= hit;
      way_q <= hit ? hit_way : victim;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign way_used_o  = way_q[0];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an accepted item always reaches the lookup stage next cycle
  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_LOOKUP))
    else $error("accepted item did not enter lookup");

  // the access counter advances by exactly one per finished lookup
  a_ctr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_fire |=> (ctr_q == $past(ctr_q) + CNT_W'(1)))
    else $error("access counter did not advance by one");

  // a hit must point at a valid way holding the tag
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lookup_fire && hit) |-> (rd_row_q.valid[hit_way] && (rd_row_q.tag[hit_way] == tag_q)))
    else $error("hit reported on a way that does not hold the tag");

endmodule : set_assoc_tag_store_multi_policy_top

`default_nettype wire

// File: test/set_assoc_tag_store_multi_policy_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_tag_store_multi_policy_top_test
// Self-checking bench for the two-way, four-set tag store with FIFO, LRU and
// LFU replacement chosen per access. A behavioral copy of the tag store runs
// alongside the block and predicts hit and way for every accepted item. Both
// handshake sides idle at random. The traffic is directed corners first, then
// small working sets per policy, then mixed random traffic.
// ----------------------------------------------------------------------------

module set_assoc_tag_store_multi_policy_top_test;
  import satsm_pkg::*;

  localparam int unsigned WAYS       = 2;
  localparam int unsigned SETS       = 4;
  localparam int unsigned LINE_SZ    = 4;
  localparam int unsigned TAG_W      = ADDR_W - 4;  // two offset bits, two set bits
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // unused code, acts as LFU

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned END_SETTLE     = 8;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic hit;
    logic way;
  } lookup_result_t;

  // Clock, reset and block ports; every input starts at a known value
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [ADDR_W-1:0] address_i   = '0;
  logic [MODE_W-1:0] mode_i      = MODE_FIFO;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              hit_o;
  logic              way_used_o;

  // Idling switches for the sender and the receiver
  logic tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;

  // Shadow copy of the tag store
  logic             shadow_valid [SETS][WAYS];
  logic [TAG_W-1:0] shadow_tag   [SETS][WAYS];
  logic [CNT_W-1:0] shadow_stamp [SETS][WAYS];
  logic [CNT_W-1:0] shadow_uses  [SETS][WAYS];
  logic             shadow_fptr  [SETS];
  logic [CNT_W-1:0] shadow_access_cnt;

  lookup_result_t expected_lookups_q[$];
  int unsigned    mismatch_cnt = 0;
  int unsigned    idle_cycles  = 0;

  set_assoc_tag_store_multi_policy_top #(
    .NUM_WAYS   (WAYS),
    .NUM_SETS_P (SETS),
    .LINE_BYTES (LINE_SZ)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .address_i   (address_i),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .way_used_o  (way_used_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Build a byte address from tag, set and byte offset
  function automatic logic [ADDR_W-1:0] make_addr(input logic [TAG_W-1:0] tag,
                                                  input int unsigned set_idx,
                                                  input int unsigned offset);
    return {tag, set_idx[1:0], offset[1:0]};
  endfunction

  // Look the address up in the shadow store, update it and return the
  // expected hit flag and way
  function automatic lookup_result_t predict_tag_lookup(input logic [ADDR_W-1:0] addr,
                                                        input logic [MODE_W-1:0] mode);
    lookup_result_t   res;
    int unsigned      set_idx;
    logic [TAG_W-1:0] tag;
    int unsigned      victim;
    logic             found;
    logic             lru_mode;
    set_idx  = addr[3:2];
    tag      = addr[ADDR_W-1:4];
    lru_mode = (mode == MODE_LRU);
    shadow_access_cnt = shadow_access_cnt + 1;

    for (int w = 0; w < WAYS; w++) begin
      if (shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag) begin
        if (lru_mode) shadow_stamp[set_idx][w] = shadow_access_cnt;
        if (shadow_uses[set_idx][w] != '1) shadow_uses[set_idx][w]++;
        res.hit = 1'b1;
        res.way = w[0];
        return res;
      end
    end

    if (mode == MODE_FIFO) begin
      // FIFO ignores free ways and always fills at the pointer
      victim = shadow_fptr[set_idx];
      shadow_fptr[set_idx] = ~shadow_fptr[set_idx];
    end else begin
      victim = 0;
      found  = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
        if (!found && !shadow_valid[set_idx][w]) begin
          victim = w;
          found  = 1'b1;
        end
      end
      // No free way: oldest stamp or fewest uses, lower way wins a tie
      if (!found) begin
        for (int w = 1; w < WAYS; w++) begin
          if (lru_mode ? (shadow_stamp[set_idx][w] < shadow_stamp[set_idx][victim])
                       : (shadow_uses[set_idx][w] < shadow_uses[set_idx][victim]))
            victim = w;
        end
      end
    end

    shadow_valid[set_idx][victim] = 1'b1;
    shadow_tag[set_idx][victim]   = tag;
    shadow_stamp[set_idx][victim] = lru_mode ? shadow_access_cnt : '0;
    shadow_uses[set_idx][victim]  = 1;
    res.hit = 1'b0;
    res.way = victim[0];
    return res;
  endfunction

  // Offer one item, hold it until the block takes it, then queue its result
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [MODE_W-1:0] mode);
    int unsigned gap;
    logic        took;
    if (tx_idle_en && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    mode_i     <= mode;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end
    expected_lookups_q.push_back(predict_tag_lookup(addr, mode));
  endtask

  // Drop valid and hold off until every queued result has come back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_lookups_q.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Corners: extreme addresses, byte offsets within a line, every mode code,
  // FIFO filling over a free way, LFU and LRU ties, victim by fewest uses
  // and by oldest stamp
  task automatic test_directed_corners();
    send_access(32'h0000_0000, MODE_FIFO);
    send_access(32'hFFFF_FFFF, MODE_LFU);
    send_access(32'hFFFF_FFFC, MODE_LRU);         // same line, other offset
    send_access(make_addr(0, 3, 3), MODE_SPARE);  // spare code takes the free way
    send_access(32'h0000_000F, MODE_LFU);
    // Set 1: FIFO replaces at the pointer while way 1 is still free
    send_access(make_addr(1, 1, 0), MODE_LRU);
    send_access(make_addr(2, 1, 1), MODE_FIFO);
    send_access(make_addr(3, 1, 2), MODE_LFU);
    send_access(make_addr(2, 1, 0), MODE_LFU);
    send_access(make_addr(4, 1, 0), MODE_LFU);    // fewest uses loses
    send_access(make_addr(5, 1, 0), MODE_FIFO);   // pointer moved on
    // Set 2: LRU eviction of the stale way
    send_access(make_addr(1, 2, 0), MODE_LRU);
    send_access(make_addr(2, 2, 0), MODE_LRU);
    send_access(make_addr(1, 2, 0), MODE_LRU);
    send_access(make_addr(3, 2, 0), MODE_LRU);
    send_access(make_addr(3, 2, 0), MODE_FIFO);
    // Set 0: equal use counts, then equal zero stamps from FIFO fills
    send_access(make_addr(1, 0, 0), MODE_LFU);
    send_access(make_addr(2, 0, 0), MODE_LFU);
    send_access(make_addr(3, 0, 0), MODE_FIFO);
    send_access(make_addr(4, 0, 0), MODE_FIFO);
    send_access(make_addr(5, 0, 0), MODE_LRU);
    send_access(32'hAAAA_AAAA, MODE_SPARE);
    send_access(32'h5555_5555, MODE_LRU);
  endtask

  // Working sets of three tags per set against two ways, one policy at a time;
  // tag 0 comes most often so that use counts and stamps drift apart
  task automatic test_policy_working_sets();
    logic [MODE_W-1:0] policies[4];
    int unsigned       pick;
    policies = '{MODE_FIFO, MODE_LRU, MODE_LFU, MODE_SPARE};
    foreach (policies[p]) begin
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 3);
        send_access(make_addr(TAG_W'((pick == 3) ? 0 : pick), $urandom_range(0, SETS - 1),
                              $urandom_range(0, 3)), policies[p]);
      end
    end
  endtask

  // Mixed modes over a small tag pool, with some fully random addresses;
  // open with a stretch without idling and pause for a full drain now and then
  task automatic test_random_traffic();
    logic [TAG_W-1:0]  tag_pool[6];
    logic [ADDR_W-1:0] addr;
    logic [MODE_W-1:0] mode;
    tag_pool = '{28'h0000000, 28'h0000001, 28'h0000002, 28'h0000003,
                 28'hFFFFFFF, 28'hA5A5A5A};
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int n = 0; n < 1300; n++) begin
      if (n == 300) begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
      if (n % 400 == 399) wait_for_drain();
      if ($urandom_range(0, 99) < 20)
        addr = $urandom();
      else
        addr = make_addr(tag_pool[$urandom_range(0, 5)], $urandom_range(0, SETS - 1),
                         $urandom_range(0, 3));
      mode = MODE_W'($urandom_range(0, 3));
      send_access(addr, mode);
    end
  endtask

  // Receiver: stall at random while idling is on
  always @(posedge clk_i) begin
    out_ready_i <= rx_idle_en ? ($urandom_range(0, 99) >= 30) : 1'b1;
  end

  // Check each result the block hands over against the oldest prediction;
  // sample at the falling edge, where the handshake is settled
  always @(negedge clk_i) begin : result_check
    lookup_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_lookups_q.size() == 0) begin
        report_mismatch("unexpected result, hit", -1, hit_o);
      end else begin
        want = expected_lookups_q.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", want.hit, hit_o);
        if (way_used_o !== want.way) report_mismatch("way_used", want.way, way_used_o);
      end
    end
  end

  // Watchdog: end the run when neither channel moves an item for too long
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    // Clear the shadow store to its reset contents
    for (int s = 0; s < SETS; s++) begin
      shadow_fptr[s] = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
        shadow_valid[s][w] = 1'b0;
        shadow_tag[s][w]   = '1;
        shadow_stamp[s][w] = '0;
        shadow_uses[s][w]  = '0;
      end
    end
    shadow_access_cnt = '0;

    // Hold reset, then release it on an edge
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_policy_working_sets();
    test_random_traffic();

    // Drain, then let the pipeline settle to catch stray results
    wait_for_drain();
    repeat (END_SETTLE) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_lookups_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
